// ===== rtl/irad_pkg.sv =====
`default_nettype none

package irad_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 32;

    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int ADDR_W    = $clog2(MAX_DIGITS);
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_A    = CHAR_W'(65);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic read;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic last_step;
        logic div_done;
        logic rd_last;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_digits.sv =====
// division: restoring and bit-serial, one pass over the value per digit;
//   the digits are then read out of the remainder store, high digit first
// input: one value at a time, in_stall stays high until its last digit is pushed;
//   bit-serial divider (one quotient bit per cycle), single read port on the store
// reset: asynchronous active low; radix returns to 10, no transaction pending
`default_nettype none

module integer_to_radix_digits (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // radix register write
    input  wire logic                            cfg_we,
    input  wire logic [irad_pkg::RADIX_W-1:0]    cfg_wdata,
    // input transaction
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [irad_pkg::VALUE_BITS-1:0] value,
    // output transaction, one per digit
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [irad_pkg::CHAR_W-1:0]          digit_char,
    output logic                                 last_digit
);

    // command and status between sequencer and datapath
    irad_pkg::cmd_t    cmd;
    irad_pkg::status_t sts;

    // sequencer: idle, divide, read store, push digit
    irad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // divider, remainder store and output register
    irad_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .value      (value),
        .cmd        (cmd),
        .out_stall  (out_stall),
        .sts        (sts),
        .out_valid  (out_valid),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

`default_nettype wire

// ===== rtl/irad_ctrl.sv =====
`default_nettype none

module irad_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire irad_pkg::status_t sts,
    output irad_pkg::cmd_t         cmd,
    output logic                   in_stall
);

    irad_pkg::state_t state_reg;
    irad_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            irad_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = irad_pkg::ST_DIVIDE;
                end
            end
            irad_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.last_step && sts.div_done)
                begin
                    state_next = irad_pkg::ST_READ;
                end
            end
            irad_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = irad_pkg::ST_PUSH;
            end
            irad_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = sts.rd_last ? irad_pkg::ST_IDLE : irad_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = irad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/irad_dp.sv =====
`default_nettype none

module irad_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [irad_pkg::RADIX_W-1:0]        cfg_wdata,
    input  wire logic [irad_pkg::VALUE_BITS-1:0]     value,
    input  wire irad_pkg::cmd_t                      cmd,
    input  wire logic                                out_stall,
    output irad_pkg::status_t                        sts,
    output logic                                     out_valid,
    output logic [irad_pkg::CHAR_W-1:0]              digit_char,
    output logic                                     last_digit
);

    logic [irad_pkg::RADIX_W-1:0]    radix_reg;
    logic [irad_pkg::RADIX_W-1:0]    div_reg;
    logic [irad_pkg::RADIX_W-1:0]    radix_eff;
    logic [irad_pkg::VALUE_BITS-1:0] quo_reg;
    logic [irad_pkg::VALUE_BITS-1:0] quo_next;
    logic [irad_pkg::DIGIT_W-1:0]    rem_reg;
    logic [irad_pkg::DIGIT_W-1:0]    rem_next;
    logic [irad_pkg::RADIX_W-1:0]    trial;
    logic [irad_pkg::BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [irad_pkg::CNT_W-1:0]      count_reg;
    logic [irad_pkg::ADDR_W-1:0]     ptr_reg;
    logic [irad_pkg::DIGIT_W-1:0]    rd_data_reg;
    logic                            out_valid_reg;
    logic [irad_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;

    logic [irad_pkg::DIGIT_W-1:0] store [irad_pkg::MAX_DIGITS];

    // clamp radix into 2..16
    always_comb
    begin
        if (radix_reg < irad_pkg::RADIX_MIN)
        begin
            radix_eff = irad_pkg::RADIX_MIN;
        end
        else if (radix_reg > irad_pkg::RADIX_MAX)
        begin
            radix_eff = irad_pkg::RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // one restoring division bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[irad_pkg::VALUE_BITS-1]};
        if (trial >= div_reg)
        begin
            rem_next = irad_pkg::DIGIT_W'(trial - div_reg);
            quo_next = {quo_reg[irad_pkg::VALUE_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[irad_pkg::DIGIT_W-1:0];
            quo_next = {quo_reg[irad_pkg::VALUE_BITS-2:0], 1'b0};
        end
    end

    assign sts.last_step = (bit_cnt_reg == irad_pkg::BIT_CNT_W'(irad_pkg::VALUE_BITS - 1));
    assign sts.div_done  = (quo_next == '0)
                        || (count_reg == irad_pkg::CNT_W'(irad_pkg::MAX_DIGITS - 1));
    assign sts.rd_last   = (ptr_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= irad_pkg::RADIX_RESET;
            div_reg       <= irad_pkg::RADIX_RESET;
            quo_reg       <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                div_reg     <= radix_eff;
                quo_reg     <= value;
                rem_reg     <= '0;
                bit_cnt_reg <= '0;
                count_reg   <= '0;
            end
            else if (cmd.step)
            begin
                quo_reg <= quo_next;
                if (sts.last_step)
                begin
                    rem_reg     <= '0;
                    bit_cnt_reg <= '0;
                    count_reg   <= count_reg + irad_pkg::CNT_W'(1);
                    ptr_reg     <= count_reg[irad_pkg::ADDR_W-1:0];
                end
                else
                begin
                    rem_reg     <= rem_next;
                    bit_cnt_reg <= bit_cnt_reg + irad_pkg::BIT_CNT_W'(1);
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
                ptr_reg       <= ptr_reg - irad_pkg::ADDR_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // remainder store and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && sts.last_step)
        begin
            store[count_reg[irad_pkg::ADDR_W-1:0]] <= rem_next;
        end
        if (cmd.read)
        begin
            rd_data_reg <= store[ptr_reg];
        end
        if (cmd.push)
        begin
            char_reg <= irad_pkg::digit_to_ascii(rd_data_reg);
            last_reg <= sts.rd_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

`default_nettype wire

// ===== tb/tb_integer_to_radix_digits.sv =====
`timescale 1ns / 100ps

module tb_integer_to_radix_digits;

    // clock period is 10 ns, reset held for RESET_CYCLES clocks
    localparam int RESET_CYCLES = 12;
    // longest stretch with no transaction on either channel before giving up;
    // worst correct case is a held receiver plus a full 31-digit division
    localparam int STUCK_LIMIT  = 10000;
    // receiver hold-off used to fill the block and stall its input
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last digit, well past one division step
    localparam int END_SETTLE   = 100;

    localparam logic [irad_pkg::VALUE_BITS-1:0] VALUE_TOP = {irad_pkg::VALUE_BITS{1'b1}};

    localparam byte CH_ZERO = "0";
    localparam byte CH_A    = "A";

    // one expected digit transaction
    typedef struct packed {
        logic [irad_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [irad_pkg::RADIX_W-1:0]    cfg_wdata;
    logic                            in_valid;
    logic                            in_stall;
    logic [irad_pkg::VALUE_BITS-1:0] value;
    logic                            out_valid;
    logic                            out_stall;
    logic [irad_pkg::CHAR_W-1:0]     digit_char;
    logic                            last_digit;

    // predictor copy of the radix register
    logic [irad_pkg::RADIX_W-1:0]    radix_reg;
    // digits still owed by the block, oldest first
    digit_t                          expected_chars[$];

    int                              fail_count = 0;
    // idling switches for each side
    bit                              source_gaps = 1'b0;
    bit                              sink_bursts = 1'b0;
    // set by a test, cleared by the receiver once its hold-off is done
    bit                              hold_request = 1'b0;

    integer_to_radix_digits uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: divide by the effective radix, keep remainders low digit
    // first, then queue characters high digit first with the last mark
    // ------------------------------------------------------------------
    function automatic void predict_digit_chars(input logic [irad_pkg::VALUE_BITS-1:0] v);
        logic [irad_pkg::RADIX_W-1:0]    base;
        logic [irad_pkg::DIGIT_W-1:0]    rems[irad_pkg::MAX_DIGITS];
        logic [irad_pkg::VALUE_BITS-1:0] quot;
        int                              n;
        digit_t                          d;
        // register values outside 2..16 are clamped to the nearest end
        base = radix_reg;
        if (base < irad_pkg::RADIX_MIN)
        begin
            base = irad_pkg::RADIX_MIN;
        end
        else if (base > irad_pkg::RADIX_MAX)
        begin
            base = irad_pkg::RADIX_MAX;
        end
        quot = v;
        n    = 0;
        // zero still yields one digit
        do
        begin
            rems[n] = irad_pkg::DIGIT_W'(quot % base);
            quot    = quot / base;
            n++;
        end
        while (quot != 0 && n < irad_pkg::MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            if (rems[k] < 10)
            begin
                d.ch = irad_pkg::CHAR_W'(CH_ZERO + rems[k]);
            end
            else
            begin
                d.ch = irad_pkg::CHAR_W'(CH_A + rems[k] - 10);
            end
            d.last = (k == 0);
            expected_chars.push_back(d);
        end
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // monitor: sampled at the rising edge, compares digit transactions and
    // feeds accepted values to the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : digit_checker
        digit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected digit transaction, expected none, actual %0d/%0d",
                         $time, digit_char, last_digit);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (digit_char !== want.ch)
                begin
                    note_mismatch("digit_char", int'(want.ch), int'(digit_char));
                end
                if (last_digit !== want.last)
                begin
                    note_mismatch("last_digit", int'(want.last), int'(last_digit));
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predict_digit_chars(value);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run once nothing has moved for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("timeout at %0t", $time);
        $display("** integer_to_radix_digits: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, or one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall    <= 1'b0;
                hold_request = 1'b0;
            end
            else if (sink_bursts && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one value and return at the falling edge after it is taken;
    // valid stays high so back-to-back transactions need no re-raise
    task automatic send_value(input logic [irad_pkg::VALUE_BITS-1:0] v);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!(in_valid && !in_stall)) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every owed digit
    task automatic finish_values();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge clk);
    endtask

    // radix write, only while the block is idle
    task automatic write_radix(input logic [irad_pkg::RADIX_W-1:0] r);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        radix_reg = r;
    endtask

    // random value with a spread of magnitudes, so short digit strings show up
    function automatic logic [irad_pkg::VALUE_BITS-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        else if (pick == 1)
        begin
            return VALUE_TOP;
        end
        return irad_pkg::VALUE_BITS'($urandom() >> $urandom_range(1, 31));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset radix of ten, including zero and the largest value
    task automatic test_reset_radix();
        send_value('0);
        send_value(1);
        send_value(9);
        send_value(10);
        send_value(VALUE_TOP);
        send_value(123456789);
        finish_values();
    endtask

    // both ends of the radix range, every hex digit, and clamped settings
    task automatic test_radix_extremes();
        write_radix(2);
        send_value('0);
        send_value(1);
        send_value(VALUE_TOP);
        send_value(31'h2AAA_AAAA);
        finish_values();
        write_radix(16);
        send_value(31'h7654_3210);
        send_value(31'h7EDC_BA98);
        send_value(31'h4000_0000);
        finish_values();
        // below two acts as binary
        write_radix(0);
        send_value(5);
        finish_values();
        write_radix(1);
        send_value(6);
        finish_values();
        // above sixteen acts as hex
        write_radix(17);
        send_value(31'hAB_CDEF);
        finish_values();
        write_radix(31);
        send_value(255);
        finish_values();
        write_radix(3);
        send_value(VALUE_TOP);
        finish_values();
        write_radix(7);
        send_value(48);
        finish_values();
    endtask

    // random values in blocks, a new radix per block, idling on both sides
    task automatic test_random_values();
        logic [irad_pkg::RADIX_W-1:0] block_radix[4];
        block_radix = '{5'd2, 5'd16, 5'd0, 5'd31};
        source_gaps = 1'b1;
        sink_bursts = 1'b1;
        for (int blk = 0; blk < 8; blk++)
        begin
            if (blk < 4)
            begin
                write_radix(block_radix[blk]);
            end
            else
            begin
                write_radix(irad_pkg::RADIX_W'($urandom_range(0, 31)));
            end
            repeat (40) send_value(random_value());
            finish_values();
        end
    endtask

    // long receiver hold-off while short values keep coming, so the input stalls
    task automatic test_backpressure();
        source_gaps = 1'b0;
        write_radix(16);
        hold_request = 1'b1;
        repeat (12) send_value(irad_pkg::VALUE_BITS'($urandom_range(0, 255)));
        finish_values();
        source_gaps = 1'b1;
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        source_gaps = 1'b0;
        sink_bursts = 1'b0;
        write_radix(10);
        repeat (30) send_value(random_value());
        finish_values();
        write_radix(irad_pkg::RADIX_W'($urandom_range(2, 16)));
        repeat (30) send_value(random_value());
        finish_values();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        value     = '0;
        radix_reg = irad_pkg::RADIX_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_radix();
        test_radix_extremes();
        test_random_values();
        test_backpressure();
        test_full_rate();

        // nothing owed now; watch a while longer for stray digits
        repeat (END_SETTLE) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("** integer_to_radix_digits: PASSED **");
        end
        else
        begin
            $display("** integer_to_radix_digits: FAILED **");
        end
        $finish;
    end

endmodule
